@@ rtl/core/btag_pkg.sv @@
package btag_pkg;

    // Field widths
    localparam int unsigned SIZE_W   = 4;
    localparam int unsigned DIM_W    = 12;
    localparam int unsigned STRIDE_W = 14;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned INDEX_W  = 26;
    localparam int unsigned OFF_W    = 6;
    localparam int unsigned CHAN_W   = 2;
    localparam int unsigned TILE_W   = 2 * DIM_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Shared divider operand widths
    localparam int unsigned DIV_NUM_W = INDEX_W;
    localparam int unsigned DIV_DEN_W = DIM_W;

    // Defaults
    localparam int unsigned MAX_TILE_SIZE_DEF = 8;
    localparam logic [SIZE_W-1:0] TILE_SIZE_RST = 4'd8;
    localparam logic [CHAN_W-1:0] CHANNELS      = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 3'd5;

    // Which quotient the shared divider is working on
    typedef enum logic [1:0] {
        DIV_WIDTH,
        DIV_HEIGHT,
        DIV_TILE
    } t_div_sel;

    // Controller to datapath
    typedef struct packed {
        logic     take;
        logic     div_start;
        t_div_sel div_sel;
        logic     count;
        logic     set_grey;
        logic     set_colour;
        logic     origin;
        logic     row_term;
        logic     base;
        logic     emit;
        logic     emit_err;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic in_range;
        logic color;
        logic last_pixel;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/btag_if.sv @@
// Block request channel
interface btag_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [btag_pkg::INDEX_W-1:0] block_index;

    modport source (output valid, output op, output block_index, input ready);
    modport sink   (input valid, input op, input block_index, output ready);
endinterface

// Address result channel
interface btag_res_if;
    logic                        valid;
    logic                        ready;
    logic [btag_pkg::ADDR_W-1:0] pixel_address;
    logic [btag_pkg::OFF_W-1:0]  buffer_offset;
    logic                        is_write;
    logic                        index_error;
    logic                        last;

    modport source (output valid, output pixel_address, output buffer_offset,
                    output is_write, output index_error, output last, input ready);
    modport sink   (input valid, input pixel_address, input buffer_offset,
                    input is_write, input index_error, input last, output ready);
endinterface

// Configuration write channel
interface btag_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [btag_pkg::CFG_IDX_W-1:0]  index;
    logic [btag_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/btag_div.sv @@
module btag_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [btag_pkg::DIV_NUM_W-1:0]   i_dividend,
    input  logic [btag_pkg::DIV_DEN_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [btag_pkg::DIV_NUM_W-1:0]   o_quotient,
    output logic [btag_pkg::DIV_DEN_W-1:0]   o_remainder
);
    import btag_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_NUM_W - 1);

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W+1:0] w_diff;
    logic                 w_fits;

    // One restoring step: shift in the next dividend bit, trial subtract
    assign w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};
    assign w_fits  = ~w_diff[DIV_DEN_W+1];

    // Control: busy for one step per quotient bit, done pulses after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/core/btag_datapath.sv @@
module btag_datapath #(
    parameter int unsigned MAX_TILE_SIZE = btag_pkg::MAX_TILE_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  btag_pkg::t_cmd   i_cmd,
    output btag_pkg::t_sts   o_sts,
    btag_req_if.sink         i_req,
    btag_res_if.source       o_res,
    btag_cfg_if.sink         i_cfg
);
    import btag_pkg::*;

    localparam int unsigned CW       = (MAX_TILE_SIZE > 1) ? $clog2(MAX_TILE_SIZE) : 1;
    localparam int unsigned MAX_CLIP = (MAX_TILE_SIZE > 15) ? 15 : MAX_TILE_SIZE;
    localparam logic [SIZE_W-1:0] SIZE_CLIP = SIZE_W'(MAX_CLIP);

    // Reciprocal of three, exact for any index of the field width
    localparam int unsigned THIRD_SHIFT = INDEX_W + 1;
    localparam logic [INDEX_W-1:0] THIRD_RECIP = INDEX_W'((2 ** THIRD_SHIFT + 2) / 3);

    // Configuration registers
    logic [SIZE_W-1:0]   r_tile_size;
    logic [DIM_W-1:0]    r_frame_width;
    logic [DIM_W-1:0]    r_frame_height;
    logic [STRIDE_W-1:0] r_line_stride;
    logic                r_color;
    logic [ADDR_W-1:0]   r_frame_base;

    // Request working registers
    logic                r_op;
    logic [INDEX_W-1:0]  r_idx;
    logic [SIZE_W-1:0]   r_size;
    logic [DIM_W-1:0]    r_wblk;
    logic [DIM_W-1:0]    r_hblk;
    logic [TILE_W-1:0]   r_count;
    logic [TILE_W-1:0]   r_tile;
    logic [CHAN_W-1:0]   r_chan;
    logic [DIM_W-1:0]    r_tx;
    logic [DIM_W-1:0]    r_ty;
    logic [DIM_W-1:0]    r_ox;
    logic [DIM_W-1:0]    r_oy;
    logic [INDEX_W-1:0]  r_row_term;
    logic [ADDR_W-1:0]   r_col_addr;
    logic [ADDR_W-1:0]   r_row_addr;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       r_row;
    logic [OFF_W-1:0]    r_off;

    // Output register
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [OFF_W-1:0]    r_out_off;
    logic                r_out_wr;
    logic                r_out_err;
    logic                r_out_last;

    logic [DIV_NUM_W-1:0] w_dividend;
    logic [DIV_DEN_W-1:0] w_divisor;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_quo;
    logic [DIV_DEN_W-1:0] w_rem;

    logic [SIZE_W-1:0]    w_size_sat;
    logic [INDEX_W-1:0]   w_count3;
    logic [2*INDEX_W-1:0] w_third_prod;
    logic [TILE_W-1:0]    w_idx_tile;
    logic [CHAN_W-1:0]    w_idx_chan;
    logic [DIM_W+SIZE_W-1:0] w_ox_prod;
    logic [DIM_W+SIZE_W-1:0] w_oy_prod;
    logic [DIM_W+1:0]     w_xbytes;
    logic [1:0]           w_pix_bytes;
    logic                 w_col_last;
    logic                 w_row_last;
    logic                 w_out_free;

    // Configuration writes, always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size    <= TILE_SIZE_RST;
            r_frame_width  <= '0;
            r_frame_height <= '0;
            r_line_stride  <= '0;
            r_color        <= 1'b0;
            r_frame_base   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TILE_SIZE:    r_tile_size    <= i_cfg.data[SIZE_W-1:0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[DIM_W-1:0];
                CFG_LINE_STRIDE:  r_line_stride  <= i_cfg.data[STRIDE_W-1:0];
                CFG_COLOR_MODE:   r_color        <= i_cfg.data[0];
                CFG_FRAME_BASE:   r_frame_base   <= i_cfg.data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Tile size clipped to the largest supported edge
    assign w_size_sat = (r_tile_size > SIZE_CLIP) ? SIZE_CLIP : r_tile_size;

    // Shared divider operands
    always_comb begin
        case (i_cmd.div_sel)
            DIV_WIDTH: begin
                w_dividend = DIV_NUM_W'(r_frame_width);
                w_divisor  = DIV_DEN_W'(r_size);
            end
            DIV_HEIGHT: begin
                w_dividend = DIV_NUM_W'(r_frame_height);
                w_divisor  = DIV_DEN_W'(r_size);
            end
            default: begin
                w_dividend = DIV_NUM_W'(r_tile);
                w_divisor  = r_wblk;
            end
        endcase
    end

    btag_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Colour split: tile by reciprocal multiply, channel from the low bits
    assign w_third_prod = (2*INDEX_W)'(r_idx) * (2*INDEX_W)'(THIRD_RECIP);
    assign w_idx_tile   = w_third_prod[THIRD_SHIFT +: TILE_W];
    assign w_idx_chan   = r_idx[CHAN_W-1:0] - w_idx_tile[CHAN_W-1:0]
                        - {w_idx_tile[0], 1'b0};

    // Block count, tripled in colour mode, for the range check
    assign w_count3 = r_color ? (INDEX_W'(r_count) + {1'b0, r_count, 1'b0})
                              : INDEX_W'(r_count);

    // Tile origin and first address of the block
    assign w_ox_prod   = (DIM_W+SIZE_W)'(r_tx) * (DIM_W+SIZE_W)'(r_size);
    assign w_oy_prod   = (DIM_W+SIZE_W)'(r_ty) * (DIM_W+SIZE_W)'(r_size);
    assign w_pix_bytes = r_color ? CHANNELS : 2'd1;
    assign w_xbytes    = r_color ? ({2'b00, r_ox} + {1'b0, r_ox, 1'b0}) : {2'b00, r_ox};

    // Walk position: rows inside a column
    assign w_col_last = (SIZE_W'(r_col) == r_size - SIZE_W'(1));
    assign w_row_last = (SIZE_W'(r_row) == r_size - SIZE_W'(1));
    assign w_out_free = ~r_out_valid | o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op   <= i_req.op;
            r_idx  <= i_req.block_index;
            r_size <= w_size_sat;
        end
        if (w_div_done) begin
            case (i_cmd.div_sel)
                DIV_WIDTH:  r_wblk <= w_quo[DIM_W-1:0];
                DIV_HEIGHT: r_hblk <= w_quo[DIM_W-1:0];
                default: begin
                    r_tx <= w_rem;
                    r_ty <= w_quo[DIM_W-1:0];
                end
            endcase
        end
        if (i_cmd.count) begin
            r_count <= TILE_W'(r_wblk) * TILE_W'(r_hblk);
        end
        if (i_cmd.set_grey) begin
            r_tile <= r_idx[TILE_W-1:0];
            r_chan <= '0;
        end
        if (i_cmd.set_colour) begin
            r_tile <= w_idx_tile;
            r_chan <= w_idx_chan;
        end
        if (i_cmd.origin) begin
            r_ox <= w_ox_prod[DIM_W-1:0];
            r_oy <= w_oy_prod[DIM_W-1:0];
        end
        if (i_cmd.row_term) begin
            r_row_term <= INDEX_W'(r_oy) * INDEX_W'(r_line_stride);
        end
        if (i_cmd.base) begin
            r_col_addr <= r_frame_base + ADDR_W'(r_row_term) + ADDR_W'(w_xbytes)
                        + ADDR_W'(r_chan);
            r_row_addr <= r_frame_base + ADDR_W'(r_row_term) + ADDR_W'(w_xbytes)
                        + ADDR_W'(r_chan);
            r_col      <= '0;
            r_row      <= '0;
            r_off      <= '0;
        end else if (i_cmd.emit) begin
            if (w_row_last) begin
                // next column: back to the top row
                r_col      <= r_col + CW'(1);
                r_row      <= '0;
                r_col_addr <= r_col_addr + ADDR_W'(w_pix_bytes);
                r_row_addr <= r_col_addr + ADDR_W'(w_pix_bytes);
                r_off      <= OFF_W'(r_col) + OFF_W'(1);
            end else begin
                r_row      <= r_row + CW'(1);
                r_row_addr <= r_row_addr + ADDR_W'(r_line_stride);
                r_off      <= r_off + OFF_W'(r_size);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_out_addr <= '0;
            r_out_off  <= '0;
            r_out_wr   <= r_op;
            r_out_err  <= 1'b1;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_addr <= r_row_addr;
            r_out_off  <= r_off;
            r_out_wr   <= r_op;
            r_out_err  <= 1'b0;
            r_out_last <= w_col_last & w_row_last;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.pixel_address = r_out_addr;
    assign o_res.buffer_offset = r_out_off;
    assign o_res.is_write      = r_out_wr;
    assign o_res.index_error   = r_out_err;
    assign o_res.last          = r_out_last;

    // Status back to the controller
    assign o_sts.div_done   = w_div_done;
    assign o_sts.in_range   = (r_size != '0) && (r_wblk != '0) && (r_idx < w_count3);
    assign o_sts.color      = r_color;
    assign o_sts.last_pixel = w_col_last & w_row_last;
    assign o_sts.out_free   = w_out_free;

endmodule

@@ rtl/core/btag_ctrl.sv @@
module btag_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  btag_pkg::t_sts   i_sts,
    output btag_pkg::t_cmd   o_cmd
);
    import btag_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_W,
        S_DIV_H,
        S_COUNT,
        S_CHECK,
        S_ERR,
        S_DIV_T,
        S_ORIGIN,
        S_ROW_TERM,
        S_BASE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_div_start, n_div_start;

    // State and divider kick-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
        end
    end

    // Next state and command decode
    always_comb begin
        n_state        = r_state;
        n_div_start    = 1'b0;
        o_req_ready    = 1'b0;
        o_cmd          = '0;
        o_cmd.div_start = r_div_start;
        o_cmd.div_sel  = DIV_WIDTH;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.take  = 1'b1;
                    n_state     = S_DIV_W;
                    n_div_start = 1'b1;
                end
            end
            S_DIV_W: begin
                o_cmd.div_sel = DIV_WIDTH;
                if (i_sts.div_done) begin
                    n_state     = S_DIV_H;
                    n_div_start = 1'b1;
                end
            end
            S_DIV_H: begin
                o_cmd.div_sel = DIV_HEIGHT;
                if (i_sts.div_done) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.in_range) begin
                    n_state = S_ERR;
                end else begin
                    // tile number and channel, then tile position
                    if (i_sts.color) begin
                        o_cmd.set_colour = 1'b1;
                    end else begin
                        o_cmd.set_grey = 1'b1;
                    end
                    n_state     = S_DIV_T;
                    n_div_start = 1'b1;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DIV_T: begin
                o_cmd.div_sel = DIV_TILE;
                if (i_sts.div_done) begin
                    n_state = S_ORIGIN;
                end
            end
            S_ORIGIN: begin
                o_cmd.origin = 1'b1;
                n_state      = S_ROW_TERM;
            end
            S_ROW_TERM: begin
                o_cmd.row_term = 1'b1;
                n_state        = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_pixel) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/block_tile_address_generator.sv @@
// A request is taken only when the controller is idle. Block count
// and tile position come from one shared one-bit-per-cycle divider: an
// out-of-range request gives its error result after the width and height
// divisions, a valid one its first address after a further tile division,
// then one address per cycle while the output is taken, size^2 in all. The
// next request is taken once the last address is issued.
// Reset: synchronous active-low; tile size 8, other settings zero, idle.
module block_tile_address_generator #(
    parameter int unsigned MAX_TILE_SIZE = btag_pkg::MAX_TILE_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btag_req_if.sink    i_req,
    btag_res_if.source  o_res,
    btag_cfg_if.sink    i_cfg
);
    import btag_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_req_ready;

    assign i_req.ready = w_req_ready;

    // Sequencer
    btag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Arithmetic, address walk and registers
    btag_datapath #(
        .MAX_TILE_SIZE (MAX_TILE_SIZE)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .o_res   (o_res),
        .i_cfg   (i_cfg)
    );

endmodule
